FILE: rtl/gse_pkg.sv
package gse_pkg;

    localparam int PIX_W     = 8;
    localparam int PIX_MAX   = 255;
    localparam int CFG_W     = 12;
    localparam int CFG_IDX_W = 1;
    localparam int COL_OUT_W = 11;
    localparam int ROW_W     = 12;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

    localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 12'd640;
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 12'd480;

    // BT.709 luma weights, in units of 1/WEIGHT_DEN
    localparam int WEIGHT_B_NUM = 722;
    localparam int WEIGHT_G_NUM = 7152;
    localparam int WEIGHT_R_NUM = 2126;
    localparam int WEIGHT_DEN   = 10000;

    typedef struct packed {
        logic [PIX_W-1:0] blue;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] red;
        logic             start_of_frame;
    } pixel_t;

    typedef struct packed {
        logic [PIX_W-1:0]     edge_value;
        logic [COL_OUT_W-1:0] out_col;
        logic [ROW_W-1:0]     out_row;
        logic                 last_of_run;
    } result_t;

    // position class of a pixel, carried down the pipe
    typedef struct packed {
        logic has_above;
        logic has_center;
        logic inner;
        logic last_col;
        logic last_row;
    } pos_flags_t;

endpackage

FILE: rtl/gray_sobel_edge_stream.sv
// 3x3 Sobel edge detector on a raster BGR stream. Each pixel is turned into BT.709
// gray in fixed point; interior pixels give |Gx|+|Gy|, border pixels their gray,
// both saturated to 255 and rounded half up. A result comes out one row after
// its pixel, tagged with its column and row; last-row pixels come out at once.
// An item is taken every cycle while each gives at most one result and res_stall
// is low; a pixel at the end of a row or in the last row can give two or three,
// and as the result port moves one per cycle, such a pixel then holds the input
// until all but its last result have left. Results pass p1, p2 and the result
// queue before being offered. The two previous rows live in one MAX_WIDTH-entry
// line store, an entry per column holding both; it needs no clearing after reset.
module gray_sobel_edge_stream #(
    parameter int MAX_WIDTH      = 2048,
    parameter int GRAY_FRAC_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          pix_valid,
    output logic                          pix_stall,
    input  gse_pkg::pixel_t               pix,
    output logic                          res_valid,
    input  logic                          res_stall,
    output gse_pkg::result_t              res,
    input  logic                          cfg_write,
    input  logic [gse_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [gse_pkg::CFG_W-1:0]     cfg_data
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int GW = gse_pkg::PIX_W + GRAY_FRAC_BITS;

    logic [gse_pkg::CFG_W-1:0] frame_width_reg;
    logic [gse_pkg::CFG_W-1:0] frame_height_reg;

    logic                      advance;
    logic                      accept;
    logic                      load_ok;
    logic [AW-1:0]             s0_col;
    logic [AW-1:0]             rd_col;
    logic                      p1_valid;
    logic [AW-1:0]             p1_col;
    logic [gse_pkg::ROW_W-1:0] p1_row;
    logic [GW-1:0]             p1_gray;
    gse_pkg::pos_flags_t       p1_flags;
    logic [2*GW-1:0]           rd_data;
    logic [GW-1:0]             top;
    logic [GW-1:0]             mid;
    logic                      p2_valid;
    logic [AW-1:0]             p2_col;
    logic [gse_pkg::ROW_W-1:0] p2_row;
    gse_pkg::pos_flags_t       p2_flags;
    logic signed [GW+2:0]      p2_gx;
    logic signed [GW+2:0]      p2_gy;
    logic [GW-1:0]             p2_alt;
    logic [GW-1:0]             p2_mid;
    logic [GW-1:0]             p2_gray;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= gse_pkg::FRAME_WIDTH_RST;
            frame_height_reg <= gse_pkg::FRAME_HEIGHT_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                gse_pkg::CFG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                gse_pkg::CFG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // whole pipe moves together; it holds only when the result queue is busy
    assign advance   = !p2_valid || load_ok;
    assign pix_stall = !advance;
    assign accept    = pix_valid && advance;

    // a held item keeps re-reading its own column
    assign rd_col = advance ? s0_col : p1_col;

    gse_front #(
        .MAX_WIDTH      (MAX_WIDTH),
        .GRAY_FRAC_BITS (GRAY_FRAC_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .pix          (pix),
        .accept       (accept),
        .advance      (advance),
        .frame_width  (frame_width_reg),
        .frame_height (frame_height_reg),
        .rd_col       (s0_col),
        .p1_valid     (p1_valid),
        .p1_col       (p1_col),
        .p1_row       (p1_row),
        .p1_gray      (p1_gray),
        .p1_flags     (p1_flags)
    );

    gse_line_buf #(
        .MAX_WIDTH      (MAX_WIDTH),
        .GRAY_FRAC_BITS (GRAY_FRAC_BITS)
    ) u_line_buf (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_col  (rd_col),
        .wr_en   (advance && p1_valid),
        .wr_col  (p1_col),
        .wr_data ({mid, p1_gray}),
        .rd_data (rd_data)
    );

    assign top = rd_data[2*GW-1:GW];
    assign mid = rd_data[GW-1:0];

    gse_window #(
        .MAX_WIDTH      (MAX_WIDTH),
        .GRAY_FRAC_BITS (GRAY_FRAC_BITS)
    ) u_window (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .p1_valid (p1_valid),
        .p1_col   (p1_col),
        .p1_row   (p1_row),
        .p1_gray  (p1_gray),
        .p1_flags (p1_flags),
        .top      (top),
        .mid      (mid),
        .p2_valid (p2_valid),
        .p2_col   (p2_col),
        .p2_row   (p2_row),
        .p2_flags (p2_flags),
        .p2_gx    (p2_gx),
        .p2_gy    (p2_gy),
        .p2_alt   (p2_alt),
        .p2_mid   (p2_mid),
        .p2_gray  (p2_gray)
    );

    gse_result #(
        .MAX_WIDTH      (MAX_WIDTH),
        .GRAY_FRAC_BITS (GRAY_FRAC_BITS)
    ) u_result (
        .clk       (clk),
        .rst_n     (rst_n),
        .p2_valid  (p2_valid),
        .p2_col    (p2_col),
        .p2_row    (p2_row),
        .p2_flags  (p2_flags),
        .p2_gx     (p2_gx),
        .p2_gy     (p2_gy),
        .p2_alt    (p2_alt),
        .p2_mid    (p2_mid),
        .p2_gray   (p2_gray),
        .res_stall (res_stall),
        .load_ok   (load_ok),
        .res_valid (res_valid),
        .res       (res)
    );

endmodule

FILE: rtl/gse_front.sv
module gse_front #(
    parameter int MAX_WIDTH      = 2048,
    parameter int GRAY_FRAC_BITS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  gse_pkg::pixel_t              pix,
    input  logic                         accept,
    input  logic                         advance,
    input  logic [gse_pkg::CFG_W-1:0]    frame_width,
    input  logic [gse_pkg::CFG_W-1:0]    frame_height,
    output logic [$clog2(MAX_WIDTH)-1:0] rd_col,
    output logic                         p1_valid,
    output logic [$clog2(MAX_WIDTH)-1:0] p1_col,
    output logic [gse_pkg::ROW_W-1:0]    p1_row,
    output logic [gse_pkg::PIX_W+GRAY_FRAC_BITS-1:0] p1_gray,
    output gse_pkg::pos_flags_t          p1_flags
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int GW = gse_pkg::PIX_W + GRAY_FRAC_BITS;
    localparam int RW = gse_pkg::ROW_W;
    localparam int XW = (CW > gse_pkg::CFG_W) ? CW : gse_pkg::CFG_W;
    localparam logic [63:0] ONE_FX = 64'd1 << GRAY_FRAC_BITS;
    localparam logic [GW+1:0] WEIGHT_B = (GW+2)'((64'(gse_pkg::WEIGHT_B_NUM) * ONE_FX
        + 64'(gse_pkg::WEIGHT_DEN / 2)) / 64'(gse_pkg::WEIGHT_DEN));
    localparam logic [GW+1:0] WEIGHT_G = (GW+2)'((64'(gse_pkg::WEIGHT_G_NUM) * ONE_FX
        + 64'(gse_pkg::WEIGHT_DEN / 2)) / 64'(gse_pkg::WEIGHT_DEN));
    localparam logic [GW+1:0] WEIGHT_R = (GW+2)'((64'(gse_pkg::WEIGHT_R_NUM) * ONE_FX
        + 64'(gse_pkg::WEIGHT_DEN / 2)) / 64'(gse_pkg::WEIGHT_DEN));

    logic [AW-1:0]             col_cnt_reg;
    logic [AW-1:0]             col_cnt_next;
    logic [RW-1:0]             row_cnt_reg;
    logic [RW-1:0]             row_cnt_next;
    logic                      p1_valid_reg;
    logic [AW-1:0]             p1_col_reg;
    logic [RW-1:0]             p1_row_reg;
    logic [GW-1:0]             p1_gray_reg;
    gse_pkg::pos_flags_t       p1_flags_reg;

    logic [XW-1:0]             fw_ext;
    logic [CW-1:0]             w_eff;
    logic [gse_pkg::CFG_W-1:0] h_eff;
    logic [AW-1:0]             c0;
    logic [RW-1:0]             r0;
    logic                      wrap_c;
    logic [RW:0]               r1;
    logic [AW-1:0]             col;
    logic [RW-1:0]             row;
    logic [CW-1:0]             colp;
    logic [RW:0]               rowp;
    gse_pkg::pos_flags_t       flags;
    logic [GW+1:0]             gray_sum;

    always_comb
    begin
        fw_ext = XW'(frame_width);
        if (frame_width == '0)
            w_eff = CW'(1);
        else if (fw_ext > XW'(MAX_WIDTH))
            w_eff = CW'(MAX_WIDTH);
        else
            w_eff = CW'(frame_width);
        h_eff = (frame_height == '0) ? gse_pkg::CFG_W'(1) : frame_height;
    end

    // position of this pixel and of the next one
    always_comb
    begin
        c0     = pix.start_of_frame ? '0 : col_cnt_reg;
        r0     = pix.start_of_frame ? '0 : row_cnt_reg;
        wrap_c = CW'(c0) >= w_eff;
        col    = wrap_c ? '0 : c0;
        r1     = {1'b0, r0} + (RW+1)'(wrap_c);
        row    = (r1 >= {1'b0, h_eff}) ? '0 : r1[RW-1:0];
        colp   = CW'(col) + CW'(1);
        rowp   = {1'b0, row} + (RW+1)'(1);
        if (colp >= w_eff)
        begin
            col_cnt_next = '0;
            row_cnt_next = (rowp >= {1'b0, h_eff}) ? '0 : rowp[RW-1:0];
        end
        else
        begin
            col_cnt_next = AW'(colp);
            row_cnt_next = row;
        end
        flags.has_above  = row != '0;
        flags.has_center = (row != '0) && (col != '0);
        flags.inner      = (row >= RW'(2)) && (col >= AW'(2));
        flags.last_col   = CW'(col) == (w_eff - CW'(1));
        flags.last_row   = row == (h_eff - gse_pkg::CFG_W'(1));
    end

    assign gray_sum = WEIGHT_B * (GW+2)'(pix.blue)
                    + WEIGHT_G * (GW+2)'(pix.green)
                    + WEIGHT_R * (GW+2)'(pix.red);

    assign rd_col = col;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_cnt_reg  <= '0;
            row_cnt_reg  <= '0;
            p1_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                col_cnt_reg <= col_cnt_next;
                row_cnt_reg <= row_cnt_next;
            end
            if (advance)
                p1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            p1_col_reg   <= col;
            p1_row_reg   <= row;
            p1_gray_reg  <= GW'(gray_sum);
            p1_flags_reg <= flags;
        end
    end

    assign p1_valid = p1_valid_reg;
    assign p1_col   = p1_col_reg;
    assign p1_row   = p1_row_reg;
    assign p1_gray  = p1_gray_reg;
    assign p1_flags = p1_flags_reg;

    a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(accept) && $stable(frame_width)) |-> (CW'(col_cnt_reg) < w_eff))
        else $error("column counter left the row after an item");

endmodule

FILE: rtl/gse_line_buf.sv
module gse_line_buf #(
    parameter int MAX_WIDTH      = 2048,
    parameter int GRAY_FRAC_BITS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [$clog2(MAX_WIDTH)-1:0] rd_col,
    input  logic                         wr_en,
    input  logic [$clog2(MAX_WIDTH)-1:0] wr_col,
    input  logic [2*(gse_pkg::PIX_W+GRAY_FRAC_BITS)-1:0] wr_data,
    output logic [2*(gse_pkg::PIX_W+GRAY_FRAC_BITS)-1:0] rd_data
);

    localparam int DW = 2 * (gse_pkg::PIX_W + GRAY_FRAC_BITS);

    // entry: {row r-2, row r-1}
    logic [DW-1:0] line_mem [MAX_WIDTH];
    logic [DW-1:0] rd_data_reg;
    logic [DW-1:0] fwd_data_reg;
    logic          fwd_hit_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            line_mem[wr_col] <= wr_data;
        rd_data_reg  <= line_mem[rd_col];
        fwd_data_reg <= wr_data;
    end

    // read and write of one column at the same edge: take the new data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fwd_hit_reg <= 1'b0;
        else
            fwd_hit_reg <= wr_en && (wr_col == rd_col);
    end

    assign rd_data = fwd_hit_reg ? fwd_data_reg : rd_data_reg;

    a_fwd_after_write: assert property (@(posedge clk) disable iff (!rst_n)
        fwd_hit_reg |-> ($past(wr_en) && ($past(wr_col) == $past(rd_col))))
        else $error("line store forwarding without a matching write");

endmodule

FILE: rtl/gse_window.sv
module gse_window #(
    parameter int MAX_WIDTH      = 2048,
    parameter int GRAY_FRAC_BITS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         advance,
    input  logic                         p1_valid,
    input  logic [$clog2(MAX_WIDTH)-1:0] p1_col,
    input  logic [gse_pkg::ROW_W-1:0]    p1_row,
    input  logic [gse_pkg::PIX_W+GRAY_FRAC_BITS-1:0] p1_gray,
    input  gse_pkg::pos_flags_t          p1_flags,
    input  logic [gse_pkg::PIX_W+GRAY_FRAC_BITS-1:0] top,
    input  logic [gse_pkg::PIX_W+GRAY_FRAC_BITS-1:0] mid,
    output logic                         p2_valid,
    output logic [$clog2(MAX_WIDTH)-1:0] p2_col,
    output logic [gse_pkg::ROW_W-1:0]    p2_row,
    output gse_pkg::pos_flags_t          p2_flags,
    output logic signed [gse_pkg::PIX_W+GRAY_FRAC_BITS+2:0] p2_gx,
    output logic signed [gse_pkg::PIX_W+GRAY_FRAC_BITS+2:0] p2_gy,
    output logic [gse_pkg::PIX_W+GRAY_FRAC_BITS-1:0] p2_alt,
    output logic [gse_pkg::PIX_W+GRAY_FRAC_BITS-1:0] p2_mid,
    output logic [gse_pkg::PIX_W+GRAY_FRAC_BITS-1:0] p2_gray
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int GW = gse_pkg::PIX_W + GRAY_FRAC_BITS;
    localparam int SW = GW + 3;

    // 0..2: column c-1, 3..5: column c-2, rows r-2, r-1, r
    logic [GW-1:0]         win_reg [6];
    logic                  p2_valid_reg;
    logic [AW-1:0]         p2_col_reg;
    logic [gse_pkg::ROW_W-1:0] p2_row_reg;
    gse_pkg::pos_flags_t   p2_flags_reg;
    logic signed [SW-1:0]  p2_gx_reg;
    logic signed [SW-1:0]  p2_gy_reg;
    logic [GW-1:0]         p2_alt_reg;
    logic [GW-1:0]         p2_mid_reg;
    logic [GW-1:0]         p2_gray_reg;

    logic signed [SW-1:0]  e11, e12, e13, e21, e23, e31, e32, e33;
    logic signed [SW-1:0]  gx, gy;
    logic                  step;

    assign step = advance && p1_valid;

    assign e11 = SW'(win_reg[3]);
    assign e12 = SW'(win_reg[0]);
    assign e13 = SW'(top);
    assign e21 = SW'(win_reg[4]);
    assign e23 = SW'(mid);
    assign e31 = SW'(win_reg[5]);
    assign e32 = SW'(win_reg[2]);
    assign e33 = SW'(p1_gray);

    assign gx = (e13 - e11) + ((e23 - e21) <<< 1) + (e33 - e31);
    assign gy = (e11 + (e12 <<< 1) + e13) - (e31 + (e32 <<< 1) + e33);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg[0]   <= '0;
            win_reg[1]   <= '0;
            win_reg[2]   <= '0;
            win_reg[3]   <= '0;
            win_reg[4]   <= '0;
            win_reg[5]   <= '0;
            p2_valid_reg <= 1'b0;
        end
        else
        begin
            if (step)
            begin
                win_reg[3] <= win_reg[0];
                win_reg[4] <= win_reg[1];
                win_reg[5] <= win_reg[2];
                win_reg[0] <= top;
                win_reg[1] <= mid;
                win_reg[2] <= p1_gray;
            end
            if (advance)
                p2_valid_reg <= p1_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            p2_col_reg   <= p1_col;
            p2_row_reg   <= p1_row;
            p2_flags_reg <= p1_flags;
            p2_gx_reg    <= gx;
            p2_gy_reg    <= gy;
            p2_alt_reg   <= win_reg[1];
            p2_mid_reg   <= mid;
            p2_gray_reg  <= p1_gray;
        end
    end

    assign p2_valid = p2_valid_reg;
    assign p2_col   = p2_col_reg;
    assign p2_row   = p2_row_reg;
    assign p2_flags = p2_flags_reg;
    assign p2_gx    = p2_gx_reg;
    assign p2_gy    = p2_gy_reg;
    assign p2_alt   = p2_alt_reg;
    assign p2_mid   = p2_mid_reg;
    assign p2_gray  = p2_gray_reg;

endmodule

FILE: rtl/gse_result.sv
module gse_result #(
    parameter int MAX_WIDTH      = 2048,
    parameter int GRAY_FRAC_BITS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         p2_valid,
    input  logic [$clog2(MAX_WIDTH)-1:0] p2_col,
    input  logic [gse_pkg::ROW_W-1:0]    p2_row,
    input  gse_pkg::pos_flags_t          p2_flags,
    input  logic signed [gse_pkg::PIX_W+GRAY_FRAC_BITS+2:0] p2_gx,
    input  logic signed [gse_pkg::PIX_W+GRAY_FRAC_BITS+2:0] p2_gy,
    input  logic [gse_pkg::PIX_W+GRAY_FRAC_BITS-1:0] p2_alt,
    input  logic [gse_pkg::PIX_W+GRAY_FRAC_BITS-1:0] p2_mid,
    input  logic [gse_pkg::PIX_W+GRAY_FRAC_BITS-1:0] p2_gray,
    input  logic                         res_stall,
    output logic                         load_ok,
    output logic                         res_valid,
    output gse_pkg::result_t             res
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int GW = gse_pkg::PIX_W + GRAY_FRAC_BITS;
    localparam int MW = GW + 3;
    localparam logic [MW-1:0] SAT  = MW'(gse_pkg::PIX_MAX) << GRAY_FRAC_BITS;
    localparam logic [MW-1:0] HALF = MW'(1) << (GRAY_FRAC_BITS - 1);

    gse_pkg::result_t q_reg [3];
    logic [1:0]       q_cnt_reg;

    gse_pkg::result_t new_q [3];
    gse_pkg::result_t c_res, r_res, s_res;
    logic [1:0]       n;
    logic [GW+1:0]    ax, ay;
    logic [MW-1:0]    mag;
    logic [MW-1:0]    center_src;
    logic             pop;
    logic             load;

    // saturate to 255, then round half up
    function automatic logic [gse_pkg::PIX_W-1:0] round_byte(input logic [MW-1:0] v);
        logic [MW-1:0] sum;
        sum = v + HALF;
        if (v >= SAT)
            return {gse_pkg::PIX_W{1'b1}};
        return sum[GRAY_FRAC_BITS +: gse_pkg::PIX_W];
    endfunction

    assign ax  = p2_gx[MW-1] ? (GW+2)'(-p2_gx) : (GW+2)'(p2_gx);
    assign ay  = p2_gy[MW-1] ? (GW+2)'(-p2_gy) : (GW+2)'(p2_gy);
    assign mag = MW'(ax) + MW'(ay);
    assign center_src = p2_flags.inner ? mag : MW'(p2_alt);

    always_comb
    begin
        c_res.edge_value  = round_byte(center_src);
        c_res.out_col     = gse_pkg::COL_OUT_W'(p2_col - AW'(1));
        c_res.out_row     = p2_row - gse_pkg::ROW_W'(1);
        c_res.last_of_run = 1'b0;
        r_res.edge_value  = round_byte(MW'(p2_mid));
        r_res.out_col     = gse_pkg::COL_OUT_W'(p2_col);
        r_res.out_row     = p2_row - gse_pkg::ROW_W'(1);
        r_res.last_of_run = 1'b0;
        s_res.edge_value  = round_byte(MW'(p2_gray));
        s_res.out_col     = gse_pkg::COL_OUT_W'(p2_col);
        s_res.out_row     = p2_row;
        s_res.last_of_run = 1'b0;

        new_q[0] = c_res;
        new_q[1] = r_res;
        new_q[2] = s_res;
        n = 2'd0;
        if (p2_flags.has_center)
        begin
            new_q[n] = c_res;
            n = n + 2'd1;
        end
        if (p2_flags.has_above && p2_flags.last_col)
        begin
            new_q[n] = r_res;
            n = n + 2'd1;
        end
        if (p2_flags.last_row)
        begin
            new_q[n] = s_res;
            n = n + 2'd1;
        end
        if (n != 2'd0)
            new_q[n - 2'd1].last_of_run = 1'b1;
    end

    assign pop     = (q_cnt_reg != 2'd0) && !res_stall;
    assign load_ok = (q_cnt_reg == 2'd0) || ((q_cnt_reg == 2'd1) && pop);
    assign load    = p2_valid && load_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            q_cnt_reg <= 2'd0;
        else if (load)
            q_cnt_reg <= n;
        else if (pop)
            q_cnt_reg <= q_cnt_reg - 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            q_reg[0] <= new_q[0];
            q_reg[1] <= new_q[1];
            q_reg[2] <= new_q[2];
        end
        else if (pop)
        begin
            q_reg[0] <= q_reg[1];
            q_reg[1] <= q_reg[2];
        end
    end

    assign res_valid = q_cnt_reg != 2'd0;
    assign res       = q_reg[0];

    a_last_marks_end: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res.last_of_run == (q_cnt_reg == 2'd1)))
        else $error("last_of_run does not mark the final queued result");

endmodule
